### sv/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg - shared definitions for the MIDI seven-segment digit decoder
// Command and status codes, sizing constants and the character mapping used
// by the decoder's shared symbol unit.
// ----------------------------------------------------------------------------
package msd_pkg;

   // Sizing
   localparam int DIGIT_COUNT       = 12;
   localparam int PENDING_DEPTH     = 16;
   localparam int SYSEX_DIGIT_LIMIT = 16;

   // Digits a sysex commit can write at most
   localparam int DIGIT_LIMIT_A = (DIGIT_COUNT < PENDING_DEPTH) ? DIGIT_COUNT : PENDING_DEPTH;
   localparam int DIGIT_LIMIT   = (DIGIT_LIMIT_A < SYSEX_DIGIT_LIMIT) ?
                                  DIGIT_LIMIT_A : SYSEX_DIGIT_LIMIT;

   localparam int DIG_IDX_W  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int PEND_IDX_W = $clog2(PENDING_DEPTH);
   localparam int POS_W      = 5;   // stream byte position, saturates at all ones

   localparam logic [POS_W-1:0] POS_MAX        = '1;
   localparam logic [POS_W-1:0] POS_HDR_LEN    = POS_W'(6);
   localparam logic [POS_W-1:0] POS_MIN_FINAL  = POS_W'(7);
   localparam logic [POS_W-1:0] POS_PEND_DEPTH = POS_W'(PENDING_DEPTH);
   localparam logic [POS_W-1:0] POS_DIG_LIMIT  = POS_W'(DIGIT_LIMIT);
   localparam logic [POS_W-1:0] POS_SYSEX_LIM  = POS_W'(SYSEX_DIGIT_LIMIT);
   localparam logic [3:0]       DIGIT_COUNT_C  = 4'(DIGIT_COUNT - 1);

   // Command codes (request kind)
   localparam logic [1:0] CMD_CONTROL = 2'd0;
   localparam logic [1:0] CMD_NOTE    = 2'd1;
   localparam logic [1:0] CMD_SYSEX   = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_BUFFERED = 2'd0;
   localparam logic [1:0] STATUS_OK       = 2'd1;
   localparam logic [1:0] STATUS_REJECT   = 2'd2;

   // MIDI constants
   localparam logic [3:0] CC_DIGIT_BANK = 4'h4;
   localparam logic [7:0] NOTE_TIMECODE = 8'h71;
   localparam logic [7:0] NOTE_BEATS    = 8'h72;
   localparam logic [7:0] VEL_ON_LOW    = 8'h01;
   localparam logic [7:0] VEL_ON_HIGH   = 8'h7F;
   localparam logic [7:0] SYSEX_START   = 8'hF0;
   localparam logic [7:0] SYSEX_END     = 8'hF7;
   localparam logic [7:0] HDR_ZERO      = 8'h00;
   localparam logic [7:0] HDR_MFR       = 8'h66;
   localparam logic [7:0] HDR_DEV_A     = 8'h14;
   localparam logic [7:0] HDR_DEV_B     = 8'h10;
   localparam logic [7:0] HDR_CMD       = 8'h10;

   localparam logic [6:0] SYM_SPACE      = 7'h20;
   localparam logic [31:0] LOWER_CASE_SET = 32'h0036_C114;   // B D H N O Q R T U

   // 6-bit display code to ASCII: low half maps onto '@'..'_', some lowered
   function automatic logic [6:0] code_to_symbol(input logic [5:0] code);
      logic [6:0] sym;
      if (!code[5]) begin
         sym = {1'b1, LOWER_CASE_SET[code[4:0]], code[4:0]};
      end else begin
         sym = {1'b0, code};
      end
      return sym;
   endfunction

   // Expected header byte at each position of the sysex stream
   function automatic logic header_byte_ok(input logic [POS_W-1:0] pos,
                                           input logic [7:0] b);
      logic ok;
      unique case (pos)
         POS_W'(0): ok = (b == SYSEX_START);
         POS_W'(1): ok = (b == HDR_ZERO);
         POS_W'(2): ok = (b == HDR_ZERO);
         POS_W'(3): ok = (b == HDR_MFR);
         POS_W'(4): ok = (b == HDR_DEV_A) || (b == HDR_DEV_B);
         POS_W'(5): ok = (b == HDR_CMD);
         default:   ok = 1'b1;
      endcase
      return ok;
   endfunction

endpackage

### sv/midi_seven_seg_digit_decoder.sv
// ----------------------------------------------------------------------------
// midi_seven_seg_digit_decoder - control-surface MIDI to digit store decoder
// Turns control changes, notes and sysex bytes into digit writes and LED
// states, reporting each write as a response.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_* (tuser = command, tlast = end of sysex message),
//   responses leave on rsp_* (tuser = status, tlast = last response of the
//   request). One request is worked on at a time; req_tready is high only
//   while the sequencer is idle, and a request is taken even while the
//   previous response still sits in the output register.
//   Control change, note and non-final sysex requests give one response,
//   loaded into the output register in the decode state, which then
//   returns to idle for the next request.
//   A successful sysex commit walks the pending code memory through the
//   shared symbol unit one digit at a time (memory read, then load), for
//   at most DIGIT_LIMIT digits. Throughput is set by that digit loop and
//   the single memory read port.
//   When the receiver stalls, the output register holds its response and
//   the sequencer waits; nothing is dropped.
//   Reset (synchronous, active high) fills the store with spaces, clears
//   both LEDs and the stream position, and marks the header good. The
//   pending code memory is not cleared; only entries of the current message
//   are read.
// ----------------------------------------------------------------------------
module midi_seven_seg_digit_decoder (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [7:0] first_byte, [15:8] second_byte, [23:16] stream_byte
   input  logic [1:0]  req_tuser,  // [1:0] cmd
   input  logic        req_tlast,  // end_of_message
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [0] digit_valid, [4:1] digit_index, [11:5] symbol,
                                   // [12] timecode_led, [13] beats_led_on, [15:14] zero
   output logic [1:0]  rsp_tuser,  // [1:0] status
   output logic        rsp_tlast   // last_of_run
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_EMIT
   } state_type;

   localparam int DIG_IDX_W  = msd_pkg::DIG_IDX_W;
   localparam int PEND_IDX_W = msd_pkg::PEND_IDX_W;
   localparam int POS_W      = msd_pkg::POS_W;

   // sequencer and stream state
   state_type           state_ff, state_in;
   logic                tc_ff, tc_in;
   logic                bt_ff, bt_in;
   logic [POS_W-1:0]    count_ff, count_in;
   logic                hdr_ff, hdr_in;
   logic [POS_W-1:0]    digit_ff, digit_in;
   logic [POS_W-1:0]    total_ff, total_in;
   logic [1:0]          run_status_ff, run_status_in;

   // captured request
   logic [1:0]          cmd_ff, cmd_in;
   logic [7:0]          b1_ff, b1_in;
   logic [7:0]          b2_ff, b2_in;
   logic [7:0]          sb_ff, sb_in;
   logic                eom_ff, eom_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_dv_ff, rsp_dv_in;
   logic [3:0]          rsp_idx_ff, rsp_idx_in;
   logic [6:0]          rsp_sym_ff, rsp_sym_in;
   logic                rsp_tc_ff, rsp_tc_in;
   logic                rsp_bt_ff, rsp_bt_in;
   logic                rsp_last_ff, rsp_last_in;

   // digit store
   logic [6:0]          store_ff [msd_pkg::DIGIT_COUNT];
   logic                store_we;
   logic [DIG_IDX_W-1:0] store_waddr;

   // pending code memory
   logic [5:0]          pend_mem [msd_pkg::PENDING_DEPTH];
   logic [5:0]          pend_rd_ff;
   logic                pend_we;
   logic [PEND_IDX_W-1:0] pend_waddr;

   // shared symbol unit
   logic [5:0]          sym_code;
   logic [6:0]          sym;

   logic                out_free;
   logic                accept;
   logic                note_on;
   logic                hdr_next;
   logic                msg_ok;
   logic [POS_W-1:0]    pos_code;
   logic [POS_W-1:0]    msg_len;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign sym_code = (state_ff == S_EMIT) ? pend_rd_ff : b2_ff[5:0];
   assign sym      = msd_pkg::code_to_symbol(sym_code);

   assign note_on  = (b2_ff == msd_pkg::VEL_ON_LOW) || (b2_ff == msd_pkg::VEL_ON_HIGH);
   assign hdr_next = hdr_ff && msd_pkg::header_byte_ok(count_ff, sb_ff);
   assign msg_ok   = hdr_next && (count_ff >= msd_pkg::POS_MIN_FINAL) &&
                     (sb_ff == msd_pkg::SYSEX_END);
   assign pos_code = count_ff - msd_pkg::POS_HDR_LEN;
   assign msg_len  = count_ff - msd_pkg::POS_HDR_LEN;   // digit codes before the end byte

   // next-state and response logic
   always_comb begin
      state_in      = state_ff;
      tc_in         = tc_ff;
      bt_in         = bt_ff;
      count_in      = count_ff;
      hdr_in        = hdr_ff;
      digit_in      = digit_ff;
      total_in      = total_ff;
      run_status_in = run_status_ff;
      cmd_in        = cmd_ff;
      b1_in         = b1_ff;
      b2_in         = b2_ff;
      sb_in         = sb_ff;
      eom_in        = eom_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_dv_in     = rsp_dv_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_tc_in     = rsp_tc_ff;
      rsp_bt_in     = rsp_bt_ff;
      rsp_last_in   = rsp_last_ff;

      store_we      = 1'b0;
      store_waddr   = b1_ff[DIG_IDX_W-1:0];
      pend_we       = 1'b0;
      pend_waddr    = pos_code[PEND_IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_tuser;
               b1_in    = req_tdata[7:0];
               b2_in    = req_tdata[15:8];
               sb_in    = req_tdata[23:16];
               eom_in   = req_tlast;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            if (out_free) begin
               // single response by default
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = msd_pkg::STATUS_REJECT;
               rsp_dv_in     = 1'b0;
               rsp_idx_in    = '0;
               rsp_sym_in    = msd_pkg::SYM_SPACE;
               rsp_last_in   = 1'b1;

               unique case (cmd_ff)
                  msd_pkg::CMD_CONTROL: begin
                     if (b1_ff[7:4] == msd_pkg::CC_DIGIT_BANK) begin
                        rsp_status_in = msd_pkg::STATUS_OK;
                        if (b1_ff[3:0] <= msd_pkg::DIGIT_COUNT_C) begin
                           store_we   = 1'b1;
                           rsp_dv_in  = 1'b1;
                           rsp_idx_in = b1_ff[3:0];
                           rsp_sym_in = sym;
                        end
                     end
                  end

                  msd_pkg::CMD_NOTE: begin
                     if (b1_ff == msd_pkg::NOTE_TIMECODE) begin
                        tc_in         = note_on;
                        rsp_status_in = msd_pkg::STATUS_OK;
                     end else if (b1_ff == msd_pkg::NOTE_BEATS) begin
                        bt_in         = note_on;
                        rsp_status_in = msd_pkg::STATUS_OK;
                     end
                  end

                  msd_pkg::CMD_SYSEX: begin
                     hdr_in  = hdr_next;
                     pend_we = (count_ff >= msd_pkg::POS_HDR_LEN) &&
                               (pos_code < msd_pkg::POS_PEND_DEPTH);
                     if (!eom_ff) begin
                        rsp_status_in = msd_pkg::STATUS_BUFFERED;
                        if (count_ff != msd_pkg::POS_MAX) begin
                           count_in = count_ff + POS_W'(1);
                        end
                     end else begin
                        count_in = '0;
                        hdr_in   = 1'b1;
                        if (msg_ok) begin
                           // start the digit loop, response comes from it
                           rsp_valid_in  = rsp_valid_ff && !rsp_tready;
                           digit_in      = '0;
                           total_in      = (msg_len < msd_pkg::POS_DIG_LIMIT) ?
                                           msg_len : msd_pkg::POS_DIG_LIMIT;
                           run_status_in = (msg_len > msd_pkg::POS_SYSEX_LIM) ?
                                           msd_pkg::STATUS_REJECT : msd_pkg::STATUS_OK;
                           state_in      = S_FETCH;
                        end
                     end
                  end

                  default: begin
                     // unused command: reject
                  end
               endcase

               rsp_tc_in = tc_in;
               rsp_bt_in = bt_in;
            end
         end

         S_FETCH: begin
            // pending memory read of digit_ff lands in pend_rd_ff
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               store_we      = 1'b1;
               store_waddr   = digit_ff[DIG_IDX_W-1:0];
               rsp_valid_in  = 1'b1;
               rsp_status_in = run_status_ff;
               rsp_dv_in     = 1'b1;
               rsp_idx_in    = 4'(digit_ff);
               rsp_sym_in    = sym;
               rsp_tc_in     = tc_ff;
               rsp_bt_in     = bt_ff;
               rsp_last_in   = (digit_ff + POS_W'(1)) == total_ff;
               digit_in      = digit_ff + POS_W'(1);
               state_in      = rsp_last_in ? S_IDLE : S_FETCH;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, store and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tc_ff        <= 1'b0;
         bt_ff        <= 1'b0;
         count_ff     <= '0;
         hdr_ff       <= 1'b1;
         digit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < msd_pkg::DIGIT_COUNT; i++) begin
            store_ff[i] <= msd_pkg::SYM_SPACE;
         end
      end else begin
         state_ff     <= state_in;
         tc_ff        <= tc_in;
         bt_ff        <= bt_in;
         count_ff     <= count_in;
         hdr_ff       <= hdr_in;
         digit_ff     <= digit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_we) begin
            store_ff[store_waddr] <= sym;
         end
      end
      total_ff      <= total_in;
      run_status_ff <= run_status_in;
      cmd_ff        <= cmd_in;
      b1_ff         <= b1_in;
      b2_ff         <= b2_in;
      sb_ff         <= sb_in;
      eom_ff        <= eom_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dv_ff     <= rsp_dv_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_tc_ff     <= rsp_tc_in;
      rsp_bt_ff     <= rsp_bt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // pending code memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_waddr] <= sb_ff[5:0];
      end
      pend_rd_ff <= pend_mem[digit_ff[PEND_IDX_W-1:0]];
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_bt_ff, rsp_tc_ff, rsp_sym_ff, rsp_idx_ff, rsp_dv_ff};

   // assertions
   a_store_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dv_ff |-> store_ff[rsp_idx_ff[DIG_IDX_W-1:0]] == rsp_sym_ff)
      else $error("reported digit differs from the digit store");

   a_buffered_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == msd_pkg::STATUS_BUFFERED) |-> !rsp_dv_ff && rsp_last_ff)
      else $error("buffered sysex byte gave a digit or a multi-response run");

   a_loop_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) || (state_ff == S_EMIT) |-> digit_ff < total_ff)
      else $error("digit loop ran past its count");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dv_ff |-> rsp_idx_ff <= msd_pkg::DIGIT_COUNT_C)
      else $error("digit index beyond the store");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken while the previous one is still decoding");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for midi_seven_seg_digit_decoder
// Drives control change, note and sysex requests with random gaps and
// response stalls. A shadow copy of the decoder state predicts every
// response, and each response is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         HEADER_LEN   = 6;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         RUN_LIMIT_NS = 2_000_000;

   typedef enum int {
      MSG_GOOD, MSG_BAD_HEADER, MSG_BAD_END, MSG_SHORT, MSG_LONG
   } msg_kind_type;

   typedef struct packed {
      logic [1:0] status;
      logic       digit_valid;
      logic [3:0] digit_index;
      logic [6:0] symbol;
      logic       timecode_led;
      logic       beats_on;
      logic       last;
   } digit_report_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [7:0] first_byte, [15:8] second_byte, [23:16] stream_byte
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        req_tlast;   // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // [0] digit_valid, [4:1] digit_index, [11:5] symbol,
                             // [12] timecode_led, [13] beats_led_on, [15:14] zero
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        rsp_tlast;   // last_of_run

   // shadow of the decoder state
   logic [6:0]                shadow_digits  [msd_pkg::DIGIT_COUNT];
   logic [5:0]                shadow_pending [msd_pkg::PENDING_DEPTH];
   logic                      shadow_timecode;
   logic                      shadow_beats;
   logic [msd_pkg::POS_W-1:0] shadow_pos;
   logic                      shadow_hdr_good;

   digit_report_type expected_reports[$];
   int               failures   = 0;
   int               items_sent = 0;
   bit               no_gaps    = 1'b0;
   int               rsp_stall  = 0;

   midi_seven_seg_digit_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // display code to character; B D H N O Q R T U come out lower case
   function automatic logic [6:0] symbol_for_code(input logic [5:0] code);
      logic [6:0] sym;
      if (code[5]) begin
         sym = {1'b0, code};
      end else begin
         sym = 7'h40 + 7'(code);
         case (code[4:0])
            5'd2, 5'd4, 5'd8, 5'd14, 5'd15, 5'd17, 5'd18, 5'd20, 5'd21: sym = sym + 7'h20;
            default: ;
         endcase
      end
      return sym;
   endfunction

   function automatic logic header_matches(input int pos, input logic [7:0] b);
      case (pos)
         0:       return b == msd_pkg::SYSEX_START;
         1, 2:    return b == msd_pkg::HDR_ZERO;
         3:       return b == msd_pkg::HDR_MFR;
         4:       return (b == msd_pkg::HDR_DEV_A) || (b == msd_pkg::HDR_DEV_B);
         5:       return b == msd_pkg::HDR_CMD;
         default: return 1'b1;
      endcase
   endfunction

   // advance the shadow state by one request and queue the responses it causes
   task automatic decode_midi_item(input logic [1:0] cmd, input logic [7:0] b1,
                                   input logic [7:0] b2, input logic [7:0] sb,
                                   input logic eom);
      digit_report_type run[$];
      digit_report_type rec;
      logic [1:0]       status;
      logic [6:0]       sym;
      logic             on;
      int               pos;
      int               n;
      int               lim;
      rec = '0;
      case (cmd)
         msd_pkg::CMD_CONTROL: begin
            if (b1[7:4] != msd_pkg::CC_DIGIT_BANK) begin
               status = msd_pkg::STATUS_REJECT;
            end else if (int'(b1[3:0]) >= msd_pkg::DIGIT_COUNT) begin
               status = msd_pkg::STATUS_OK;
            end else begin
               sym = symbol_for_code(b2[5:0]);
               shadow_digits[b1[3:0]] = sym;
               rec.digit_valid = 1'b1;
               rec.digit_index = b1[3:0];
               rec.symbol      = sym;
               run.push_back(rec);
               status = msd_pkg::STATUS_OK;
            end
         end
         msd_pkg::CMD_NOTE: begin
            on = (b2 == msd_pkg::VEL_ON_LOW) || (b2 == msd_pkg::VEL_ON_HIGH);
            status = msd_pkg::STATUS_OK;
            if (b1 == msd_pkg::NOTE_TIMECODE) shadow_timecode = on;
            else if (b1 == msd_pkg::NOTE_BEATS) shadow_beats = on;
            else status = msd_pkg::STATUS_REJECT;
         end
         msd_pkg::CMD_SYSEX: begin
            pos = int'(shadow_pos);
            if (!header_matches(pos, sb)) shadow_hdr_good = 1'b0;
            if (pos >= HEADER_LEN && pos - HEADER_LEN < msd_pkg::PENDING_DEPTH)
               shadow_pending[pos - HEADER_LEN] = sb[5:0];
            if (!eom) begin
               if (shadow_pos != msd_pkg::POS_MAX) shadow_pos = shadow_pos + 1'b1;
               status = msd_pkg::STATUS_BUFFERED;
            end else if (!(shadow_hdr_good && pos > HEADER_LEN &&
                           sb == msd_pkg::SYSEX_END)) begin
               shadow_pos      = '0;
               shadow_hdr_good = 1'b1;
               status          = msd_pkg::STATUS_REJECT;
            end else begin
               shadow_pos      = '0;
               shadow_hdr_good = 1'b1;
               n   = pos - HEADER_LEN;
               lim = (n < msd_pkg::SYSEX_DIGIT_LIMIT) ? n : msd_pkg::SYSEX_DIGIT_LIMIT;
               for (int d = 0; d < lim; d++) begin
                  if (d < msd_pkg::DIGIT_COUNT && d < msd_pkg::PENDING_DEPTH) begin
                     sym = symbol_for_code(shadow_pending[d]);
                     shadow_digits[d] = sym;
                     rec.digit_valid = 1'b1;
                     rec.digit_index = 4'(d);
                     rec.symbol      = sym;
                     run.push_back(rec);
                  end
               end
               status = (n > msd_pkg::SYSEX_DIGIT_LIMIT) ? msd_pkg::STATUS_REJECT :
                                                           msd_pkg::STATUS_OK;
            end
         end
         default: status = msd_pkg::STATUS_REJECT;
      endcase
      // no digit written: a single blank report
      if (run.size() == 0) begin
         rec.digit_valid = 1'b0;
         rec.digit_index = '0;
         rec.symbol      = msd_pkg::SYM_SPACE;
         run.push_back(rec);
      end
      foreach (run[i]) begin
         run[i].status       = status;
         run[i].timecode_led = shadow_timecode;
         run[i].beats_on     = shadow_beats;
         run[i].last         = (i == run.size() - 1);
         expected_reports.push_back(run[i]);
      end
   endtask

   // send one request; predict at the accepting edge
   task automatic send_midi_item(input logic [1:0] cmd, input logic [7:0] b1,
                                 input logic [7:0] b2, input logic [7:0] sb,
                                 input logic eom);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= cmd;
      req_tdata  <= {sb, b2, b1};
      req_tlast  <= eom;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      decode_midi_item(cmd, b1, b2, sb, eom);
      items_sent++;
   endtask

   // one control, note or noise request; a stray sysex byte only when allowed
   task automatic send_random_single(input bit allow_stream);
      int         r;
      logic [7:0] vel;
      r = $urandom_range(0, allow_stream ? 99 : 87);
      if (r < 35) begin
         send_midi_item(msd_pkg::CMD_CONTROL, {msd_pkg::CC_DIGIT_BANK, 4'($urandom)},
                        8'($urandom), 8'($urandom), 1'($urandom));
      end else if (r < 50) begin
         send_midi_item(msd_pkg::CMD_CONTROL, 8'($urandom), 8'($urandom), 8'($urandom),
                        1'($urandom));
      end else if (r < 70) begin
         case ($urandom_range(0, 3))
            0:       vel = msd_pkg::VEL_ON_LOW;
            1:       vel = msd_pkg::VEL_ON_HIGH;
            2:       vel = 8'h00;
            default: vel = 8'($urandom);
         endcase
         send_midi_item(msd_pkg::CMD_NOTE,
                        $urandom_range(0, 1) ? msd_pkg::NOTE_TIMECODE : msd_pkg::NOTE_BEATS,
                        vel, 8'($urandom), 1'($urandom));
      end else if (r < 80) begin
         send_midi_item(msd_pkg::CMD_NOTE, 8'($urandom), 8'($urandom), 8'($urandom),
                        1'($urandom));
      end else if (r < 88) begin
         send_midi_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
         send_midi_item(msd_pkg::CMD_SYSEX, 8'($urandom), 8'($urandom), 8'($urandom),
                        1'($urandom));
      end
   endtask

   // one sysex message of the given shape with random digit codes
   task automatic send_sysex_message(input msg_kind_type kind, input int ndig);
      logic [7:0] bytes[$];
      int         corrupt;
      int         len;
      bytes.push_back(msd_pkg::SYSEX_START);
      bytes.push_back(msd_pkg::HDR_ZERO);
      bytes.push_back(msd_pkg::HDR_ZERO);
      bytes.push_back(msd_pkg::HDR_MFR);
      bytes.push_back($urandom_range(0, 1) ? msd_pkg::HDR_DEV_A : msd_pkg::HDR_DEV_B);
      bytes.push_back(msd_pkg::HDR_CMD);
      repeat (ndig) bytes.push_back(8'($urandom));
      case (kind)
         MSG_BAD_HEADER: begin
            corrupt = $urandom_range(0, HEADER_LEN - 1);
            bytes[corrupt] = bytes[corrupt] ^ 8'($urandom_range(1, 255));
            bytes.push_back(msd_pkg::SYSEX_END);
         end
         MSG_BAD_END: bytes.push_back(msd_pkg::SYSEX_END ^ 8'($urandom_range(1, 255)));
         MSG_SHORT: begin
            len = $urandom_range(1, HEADER_LEN + 1);
            while (bytes.size() > len - 1) void'(bytes.pop_back());
            bytes.push_back(msd_pkg::SYSEX_END);
         end
         default: bytes.push_back(msd_pkg::SYSEX_END);
      endcase
      foreach (bytes[i]) begin
         // control and note traffic may cut into a stream
         if (i > 0 && $urandom_range(0, 99) < 8) send_random_single(1'b0);
         send_midi_item(msd_pkg::CMD_SYSEX, 8'($urandom), 8'($urandom), bytes[i],
                        i == bytes.size() - 1);
      end
   endtask

   task automatic test_control_change();
      send_midi_item(msd_pkg::CMD_CONTROL, {msd_pkg::CC_DIGIT_BANK, 4'h0}, 8'h00, 8'h00, 1'b0);
      send_midi_item(msd_pkg::CMD_CONTROL, {msd_pkg::CC_DIGIT_BANK, 4'hB}, 8'hFF, 8'hFF, 1'b1);
      send_midi_item(msd_pkg::CMD_CONTROL, {msd_pkg::CC_DIGIT_BANK, 4'h1}, 8'h02, 8'h00, 1'b0);
      send_midi_item(msd_pkg::CMD_CONTROL, {msd_pkg::CC_DIGIT_BANK, 4'h5}, 8'h1F, 8'h00, 1'b0);
      send_midi_item(msd_pkg::CMD_CONTROL, {msd_pkg::CC_DIGIT_BANK, 4'h6}, 8'h20, 8'h00, 1'b0);
      // digit positions past the display
      send_midi_item(msd_pkg::CMD_CONTROL, {msd_pkg::CC_DIGIT_BANK, 4'hC}, 8'h41, 8'h00, 1'b0);
      send_midi_item(msd_pkg::CMD_CONTROL, {msd_pkg::CC_DIGIT_BANK, 4'hF}, 8'h7F, 8'h00, 1'b0);
      // controllers outside the digit bank
      send_midi_item(msd_pkg::CMD_CONTROL, 8'h3F, 8'h05, 8'h00, 1'b0);
      send_midi_item(msd_pkg::CMD_CONTROL, 8'h50, 8'h05, 8'h00, 1'b0);
   endtask

   task automatic test_mode_notes();
      send_midi_item(msd_pkg::CMD_NOTE, msd_pkg::NOTE_TIMECODE, msd_pkg::VEL_ON_LOW,
                     8'h00, 1'b0);
      send_midi_item(msd_pkg::CMD_NOTE, msd_pkg::NOTE_TIMECODE, msd_pkg::VEL_ON_HIGH,
                     8'h00, 1'b0);
      send_midi_item(msd_pkg::CMD_NOTE, msd_pkg::NOTE_TIMECODE, 8'h00, 8'h00, 1'b0);
      send_midi_item(msd_pkg::CMD_NOTE, msd_pkg::NOTE_BEATS, msd_pkg::VEL_ON_HIGH,
                     8'h00, 1'b0);
      send_midi_item(msd_pkg::CMD_NOTE, msd_pkg::NOTE_BEATS, 8'h02, 8'h00, 1'b0);
      send_midi_item(msd_pkg::CMD_NOTE, 8'h70, msd_pkg::VEL_ON_HIGH, 8'h00, 1'b0);
   endtask

   task automatic test_unused_command();
      send_midi_item(CMD_UNUSED, 8'h40, 8'h01, 8'hF7, 1'b1);
   endtask

   // shortest message that writes a digit
   task automatic test_sysex_minimum();
      send_sysex_message(MSG_GOOD, 1);
   endtask

   task automatic test_random_traffic(input int item_goal, input bit quiet);
      int start;
      int r;
      no_gaps = quiet;
      start = items_sent;
      while (items_sent - start < item_goal) begin
         r = $urandom_range(0, 99);
         if (r >= 55) begin
            send_random_single(1'b1);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               r = $urandom_range(0, 99);
               if (r < 8) send_sysex_message(MSG_GOOD, 0);
               else if (r < 85)
                  send_sysex_message(MSG_GOOD, $urandom_range(1, msd_pkg::DIGIT_COUNT));
               else
                  send_sysex_message(MSG_GOOD, $urandom_range(msd_pkg::DIGIT_COUNT + 1, 19));
            end else if (r < 72) begin
               send_sysex_message(MSG_BAD_HEADER, $urandom_range(1, msd_pkg::DIGIT_COUNT));
            end else if (r < 82) begin
               send_sysex_message(MSG_BAD_END, $urandom_range(1, msd_pkg::DIGIT_COUNT));
            end else if (r < 92) begin
               send_sysex_message(MSG_SHORT, 0);
            end else begin
               send_sysex_message(MSG_LONG, $urandom_range(27, 34));
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   // response side stalls
   always @(negedge clock) begin : stall_responses
      int gap;
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         gap = pick_gap();
         rsp_tready <= (gap == 0);
         if (gap > 0) rsp_stall = gap - 1;
      end
   end

   // check each response against the oldest prediction
   always @(posedge clock) begin : check_responses
      digit_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, actual tdata %h tuser %0d",
                     $time, rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = expected_reports.pop_front();
            compare_field("status", want.status, rsp_tuser);
            compare_field("digit_valid", want.digit_valid, rsp_tdata[0]);
            compare_field("digit_index", want.digit_index, rsp_tdata[4:1]);
            compare_field("symbol", want.symbol, rsp_tdata[11:5]);
            compare_field("timecode_led", want.timecode_led, rsp_tdata[12]);
            compare_field("beats_led_on", want.beats_on, rsp_tdata[13]);
            compare_field("tdata pad", 0, rsp_tdata[15:14]);
            compare_field("last_of_run", want.last, rsp_tlast);
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = msd_pkg::CMD_CONTROL;
      req_tlast  = 1'b0;
      foreach (shadow_digits[i]) shadow_digits[i] = msd_pkg::SYM_SPACE;
      foreach (shadow_pending[i]) shadow_pending[i] = '0;
      shadow_timecode = 1'b0;
      shadow_beats    = 1'b0;
      shadow_pos      = '0;
      shadow_hdr_good = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_control_change();
      test_mode_notes();
      test_unused_command();
      test_sysex_minimum();
      test_random_traffic(245, 1'b0);
      test_random_traffic(55, 1'b1);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
